/* design/array_list_engine_core_assert.svh */
// Assertion macros used by the checker file ale_checker.sv
`ifndef ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define ALE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ALE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg
// Types and constants of the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;
  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] K_INSERT = 3'd0;
  localparam logic [2:0] K_DELETE = 3'd1;
  localparam logic [2:0] K_LSEARCH = 3'd2;
  localparam logic [2:0] K_BSEARCH = 3'd3;
  localparam logic [2:0] K_AVERAGE = 3'd4;
  localparam logic [2:0] K_REVERSE = 3'd5;
  localparam logic [2:0] K_READALL = 3'd6;
  localparam logic [2:0] K_NOP = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [31:0] value;
    logic [6:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] index;
    logic signed [31:0] data;
    logic signed [39:0] mean;
    logic [6:0] count;
    logic last;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic signed [47:0] dividend;
    logic [CW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [47:0] quotient;
  } div_rsp_t;
endpackage

/* design/ale_ram.sv */
// ----------------------------------------------------------------------------
// ale_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ale_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* design/ale_div.sv */
// ----------------------------------------------------------------------------
// ale_div
// Restoring signed divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module ale_div (
  input  logic              clk,
  input  logic              rst,
  input  ale_pkg::div_req_t req,
  output ale_pkg::div_rsp_t rsp
);
  import ale_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  step;
  logic [47:0] quo;
  logic [CW:0] rem;
  logic [CW-1:0] dvs;
  logic        neg;
  logic [CW:0] trial;

  assign trial = {rem[CW-1:0], quo[47]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 6'd0;
        neg <= req.dividend[47];
        quo <= req.dividend[47] ? 48'(-req.dividend) : 48'(req.dividend);
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[46:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: (neg ? -$signed(quo) : $signed(quo))};
endmodule

/* design/array_list_engine_core.sv */
// ----------------------------------------------------------------------------
// array_list_engine_core
// Bounded list of signed words held in one RAM; sequencer walks it one
// access at a time for shift, search, average, reverse and readout.
// ----------------------------------------------------------------------------
//  channel | signals                  | payload
//  req     | req_valid / req_ready    | ale_pkg::req_t
//  rsp     | rsp_valid / rsp_ready    | ale_pkg::rsp_t
//
// One request at a time; each entry touched takes a RAM read, a wait, then a
// write or compare; reverse reads both entries of a pair, then writes both;
// average then runs the divider. Up to 64 entries are walked.
// Read all gives one beat per entry, paced by rsp_ready.
// Reset empties the list at once; no clearing pass.
module array_list_engine_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ale_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ale_pkg::rsp_t  rsp
);
  import ale_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_USE, S_WR, S_DIV, S_OUT, S_RDOUT
  } state_t;

  state_t state;
  req_t   cur;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW:0]   lo;
  logic [CW:0]   hi;
  logic [CW-1:0] mid;
  logic [31:0]   hold;
  logic          phase;
  logic signed [47:0] sum;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata;
  logic [31:0]   rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic [1:0]    acc_status;
  logic [CW-1:0] acc_i;

  ale_ram #(.DEPTH(CAPACITY), .WIDTH(32)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  ale_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign req_ready = (state == S_IDLE) && !rsp_valid;

  // status and start index of an incoming beat
  always_comb begin
    acc_status = ST_OK;
    acc_i = '0;
    if (req.kind == K_INSERT) begin
      acc_i = count;
      if (req.position > 7'(count)) begin
        acc_status = ST_BADPOS;
      end else if (count == CW'(CAPACITY)) begin
        acc_status = ST_FULL;
      end
    end else if (req.kind == K_DELETE) begin
      acc_i = CW'(req.position);
      if (req.position >= 7'(count)) begin
        acc_status = ST_BADPOS;
      end
    end
  end

  // RAM access pattern per kind:
  //  insert: read i-1, write i (i from count down to pos+1), then write pos
  //  delete: read i+1, write i
  //  reverse: read i, read j, write i, write j
  // read address held through the wait cycle so rdata stays on that entry
  always_comb begin
    we = 1'b0;
    addr = AW'(i);
    wdata = hold;
    dreq.start = 1'b0;
    dreq.dividend = sum <<< 8;
    dreq.divisor = count;
    unique case (state)
      S_RD, S_WAIT: begin
        unique case (cur.kind)
          K_INSERT: addr = AW'(i - CW'(1));
          K_DELETE: addr = AW'(i + CW'(1));
          K_BSEARCH: addr = AW'(mid);
          K_REVERSE: addr = phase ? AW'(j) : AW'(i);
          default: addr = AW'(i);
        endcase
      end
      S_WR: begin
        we = 1'b1;
        unique case (cur.kind)
          K_INSERT: begin
            if (i == CW'(cur.position)) begin
              wdata = cur.value;
            end else begin
              wdata = rdata;
            end
          end
          K_DELETE: wdata = rdata;
          K_REVERSE: begin
            addr = phase ? AW'(j) : AW'(i);
            wdata = phase ? hold : rdata;
          end
          default: we = 1'b0;
        endcase
      end
      S_DIV: dreq.start = !phase;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            cur <= req;
            rsp <= '{status: acc_status, index: '0, data: '0, mean: '0,
                     count: 7'(count), last: 1'b1};
            i <= acc_i;
            phase <= 1'b0;
            sum <= '0;
            lo <= '0;
            hi <= {1'b0, count} - (CW+1)'(1);
            j <= count - CW'(1);
            mid <= CW'(({1'b0, count} - (CW+1)'(1)) >> 1);
            unique case (req.kind)
              K_INSERT: begin
                if (acc_status != ST_OK) begin
                  state <= S_OUT;
                end else begin
                  state <= (CW'(req.position) == count) ? S_WR : S_RD;
                end
              end
              K_DELETE: begin
                if (acc_status != ST_OK) begin
                  state <= S_OUT;
                end else begin
                  state <= (CW'(req.position) + CW'(1) == count) ? S_USE : S_RD;
                end
              end
              K_LSEARCH, K_AVERAGE, K_READALL: begin
                state <= (count == '0) ? (req.kind == K_AVERAGE ? S_OUT : S_USE)
                                       : S_RD;
              end
              K_BSEARCH: state <= (count == '0) ? S_USE : S_RD;
              K_REVERSE: state <= (count < CW'(2)) ? S_OUT : S_RD;
              default: state <= S_OUT;
            endcase
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: begin
          if (cur.kind == K_REVERSE) begin
            if (!phase) begin
              hold <= rdata;
              phase <= 1'b1;
              state <= S_RD;
            end else begin
              phase <= 1'b0;
              state <= S_WR;
            end
          end else begin
            state <= (cur.kind == K_INSERT || cur.kind == K_DELETE) ? S_WR : S_USE;
          end
        end
        S_USE: begin
          unique case (cur.kind)
            K_DELETE: begin
              count <= count - CW'(1);
              rsp.count <= 7'(count - CW'(1));
              state <= S_OUT;
            end
            K_LSEARCH: begin
              if (count == '0) begin
                rsp.status <= ST_MISS;
                state <= S_OUT;
              end else if (rdata == cur.value) begin
                rsp.index <= 6'(i);
                state <= S_OUT;
              end else if (i + CW'(1) == count) begin
                rsp.status <= ST_MISS;
                state <= S_OUT;
              end else begin
                i <= i + CW'(1);
                state <= S_RD;
              end
            end
            K_BSEARCH: begin
              if (count == '0) begin
                rsp.status <= ST_MISS;
                state <= S_OUT;
              end else if ($signed(rdata) == cur.value) begin
                rsp.index <= 6'(mid);
                state <= S_OUT;
              end else if ($signed(rdata) < cur.value) begin
                if ({1'b0, mid} + (CW+1)'(1) > hi) begin
                  rsp.status <= ST_MISS;
                  state <= S_OUT;
                end else begin
                  lo <= {1'b0, mid} + (CW+1)'(1);
                  mid <= CW'(({1'b0, mid} + (CW+1)'(1) + hi) >> 1);
                  state <= S_RD;
                end
              end else begin
                if (mid == '0 || {1'b0, mid} - (CW+1)'(1) < lo) begin
                  rsp.status <= ST_MISS;
                  state <= S_OUT;
                end else begin
                  hi <= {1'b0, mid} - (CW+1)'(1);
                  mid <= CW'((lo + {1'b0, mid} - (CW+1)'(1)) >> 1);
                  state <= S_RD;
                end
              end
            end
            K_AVERAGE: begin
              sum <= sum + 48'($signed(rdata));
              if (i + CW'(1) == count) begin
                state <= S_DIV;
              end else begin
                i <= i + CW'(1);
                state <= S_RD;
              end
            end
            K_READALL: begin
              rsp.last <= (count == '0) || (i + CW'(1) == count);
              rsp.index <= 6'(i);
              rsp.data <= (count == '0) ? '0 : rdata;
              rsp_valid <= 1'b1;
              state <= S_RDOUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_WR: begin
          unique case (cur.kind)
            K_INSERT: begin
              if (i == CW'(cur.position)) begin
                count <= count + CW'(1);
                rsp.count <= 7'(count + CW'(1));
                state <= S_OUT;
              end else begin
                i <= i - CW'(1);
                state <= (i - CW'(1) == CW'(cur.position)) ? S_WR : S_RD;
              end
            end
            K_DELETE: begin
              if (i + CW'(2) == count) begin
                state <= S_USE;
              end else begin
                i <= i + CW'(1);
                state <= S_RD;
              end
            end
            K_REVERSE: begin
              if (!phase) begin
                phase <= 1'b1;
                state <= S_WR;
              end else begin
                phase <= 1'b0;
                if (i + CW'(1) >= j - CW'(1)) begin
                  state <= S_OUT;
                end else begin
                  i <= i + CW'(1);
                  j <= j - CW'(1);
                  state <= S_RD;
                end
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_DIV: begin
          phase <= 1'b1;
          if (drsp.done) begin
            rsp.mean <= 40'(drsp.quotient);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_valid) begin
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RDOUT: begin
          if (rsp_valid && rsp_ready) begin
            if (rsp.last) begin
              state <= S_IDLE;
            end else begin
              i <= i + CW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/ale_checker.sv */
// ----------------------------------------------------------------------------
// ale_checker
// Port-level checks on the array list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_list_engine_core_assert.svh"

module ale_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ale_pkg::rsp_t rsp
);
  import ale_pkg::*;

  `ALE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `ALE_ASSERT_IMP(a_count_range, rsp_valid, rsp.count <= 7'(CAPACITY))
  `ALE_ASSERT_IMP(a_no_accept_busy, rsp_valid, !req_ready)
  `ALE_ASSERT_IMP(a_data_zero, rsp_valid && rsp.status != ST_OK, rsp.data == '0 && rsp.last)
  `ALE_ASSERT_NEXT(a_accept_then_busy, req_valid && req_ready, !req_ready)
endmodule

bind array_list_engine_core ale_checker u_ale_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
